/* rtl/pkfa_pkg.sv */
// Shared types and constants for the packet descriptor queue.
package pkfa_pkg;

  localparam int unsigned HANDLE_W   = 32;
  localparam int unsigned BYTES_W    = 24;
  localparam int unsigned DUR_W      = 32;
  localparam int unsigned SERIAL_W   = 32;
  localparam int unsigned BTOTAL_W   = 40;
  localparam int unsigned DTOTAL_W   = 48;
  localparam int unsigned MINPKT_W   = 16;
  localparam int unsigned TB_W       = 32;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 3;

  localparam logic [OP_W-1:0] OP_PUT   = 3'd0;
  localparam logic [OP_W-1:0] OP_GET   = 3'd1;
  localparam logic [OP_W-1:0] OP_FLUSH = 3'd2;
  localparam logic [OP_W-1:0] OP_START = 3'd3;
  localparam logic [OP_W-1:0] OP_ABORT = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ABORTED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY_WAIT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  localparam logic [REG_IDX_W-1:0] REG_MIN_PACKETS = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TB_NUM      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TB_DEN      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_STREAM_ABS  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ATTACHED    = 3'd4;

  typedef struct packed {
    logic [MINPKT_W-1:0] min_packets;
    logic [TB_W-1:0]     tb_num;
    logic [TB_W-1:0]     tb_den;
    logic                stream_absent;
    logic                attached_picture;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic mul;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [BYTES_W-1:0]  bytes;
    logic [DUR_W-1:0]    duration;
    logic [SERIAL_W-1:0] serial;
  } entry_t;

endpackage

/* rtl/pkfa_ctrl.sv */
// Sequencer for one queue transaction: capture, execute, multiply, deliver.
module pkfa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output pkfa_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_MUL, S_DONE} state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.exec     = (state == S_EXEC);
    cmd.mul      = (state == S_MUL);
    cmd.load_out = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: state <= S_MUL;
        S_MUL:  state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/pkfa_datapath.sv */
// Descriptor memory, pointers, totals, enough evaluation and result register.
module pkfa_datapath #(
  parameter int unsigned DEPTH          = 64,
  parameter int unsigned ENTRY_OVERHEAD = 16,
  parameter int unsigned CNT_W          = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pkfa_pkg::cmd_t                    cmd,
  input  pkfa_pkg::cfg_t                    cfg,
  input  logic [pkfa_pkg::OP_W-1:0]         operation,
  input  logic [pkfa_pkg::HANDLE_W-1:0]     pkt_handle,
  input  logic [pkfa_pkg::BYTES_W-1:0]      pkt_bytes,
  input  logic [pkfa_pkg::DUR_W-1:0]        pkt_duration,
  input  logic                              wait_if_empty,
  output logic [pkfa_pkg::STATUS_W-1:0]     status,
  output logic [pkfa_pkg::HANDLE_W-1:0]     out_handle,
  output logic [pkfa_pkg::BYTES_W-1:0]      out_bytes,
  output logic [pkfa_pkg::DUR_W-1:0]        out_duration,
  output logic [pkfa_pkg::SERIAL_W-1:0]     out_serial,
  output logic [CNT_W-1:0]                  packet_count,
  output logic [pkfa_pkg::BTOTAL_W-1:0]     byte_total,
  output logic [pkfa_pkg::DTOTAL_W-1:0]     duration_total,
  output logic                              enough
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [pkfa_pkg::BTOTAL_W-1:0] OVH = pkfa_pkg::BTOTAL_W'(ENTRY_OVERHEAD);

  pkfa_pkg::entry_t mem [DEPTH];
  pkfa_pkg::entry_t rdata;
  pkfa_pkg::entry_t wdata;

  logic [pkfa_pkg::OP_W-1:0]     op;
  logic [pkfa_pkg::HANDLE_W-1:0] handle_in;
  logic [pkfa_pkg::BYTES_W-1:0]  bytes_in;
  logic [pkfa_pkg::DUR_W-1:0]    dur_in;
  logic                          wait_in;

  logic [PTR_W-1:0]              rd_ptr;
  logic [PTR_W-1:0]              wr_ptr;
  logic [CNT_W-1:0]              count;
  logic [pkfa_pkg::BTOTAL_W-1:0] bytes_accum;
  logic [pkfa_pkg::DTOTAL_W-1:0] duration_accum;
  logic [pkfa_pkg::SERIAL_W-1:0] current_serial;
  logic                          aborted;

  logic [pkfa_pkg::STATUS_W-1:0] status_r;
  logic                          get_ok;
  logic                          put_ok;
  logic                          get_hit;
  logic [2*pkfa_pkg::TB_W-1:0]   prod;
  logic                          long_enough;
  logic                          enough_next;

  assign put_ok  = (op == pkfa_pkg::OP_PUT) && !aborted && (count != FULL_CNT);
  assign get_hit = (op == pkfa_pkg::OP_GET) && !aborted && (count != '0);

  always_comb begin
    wdata          = '0;
    wdata.handle   = handle_in;
    wdata.bytes    = bytes_in;
    wdata.duration = dur_in;
    wdata.serial   = current_serial;
  end

  // head entry is read at capture so the execute step sees registered data
  always_ff @(posedge clk) begin
    if (cmd.exec && put_ok) begin
      mem[wr_ptr] <= wdata;
    end
    if (cmd.load) begin
      rdata <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op        <= operation;
      handle_in <= pkt_handle;
      bytes_in  <= pkt_bytes;
      dur_in    <= pkt_duration;
      wait_in   <= wait_if_empty;
    end
    if (cmd.exec) begin
      get_ok <= get_hit;
    end
    if (cmd.mul) begin
      prod <= cfg.tb_num * duration_accum[pkfa_pkg::TB_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr         <= '0;
      wr_ptr         <= '0;
      count          <= '0;
      bytes_accum    <= '0;
      duration_accum <= '0;
      current_serial <= '0;
      aborted        <= 1'b1;
      status_r       <= pkfa_pkg::ST_OK;
    end else if (cmd.exec) begin
      status_r <= pkfa_pkg::ST_OK;
      case (op)
        pkfa_pkg::OP_PUT: begin
          if (aborted) begin
            status_r <= pkfa_pkg::ST_ABORTED;
          end else if (count == FULL_CNT) begin
            status_r <= pkfa_pkg::ST_FULL;
          end else begin
            wr_ptr         <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
            count          <= count + 1'b1;
            bytes_accum    <= bytes_accum + pkfa_pkg::BTOTAL_W'(bytes_in) + OVH;
            duration_accum <= duration_accum + pkfa_pkg::DTOTAL_W'(dur_in);
          end
        end
        pkfa_pkg::OP_GET: begin
          if (aborted) begin
            status_r <= pkfa_pkg::ST_ABORTED;
          end else if (count == '0) begin
            status_r <= wait_in ? pkfa_pkg::ST_EMPTY_WAIT : pkfa_pkg::ST_EMPTY;
          end else begin
            rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
            count  <= count - 1'b1;
            bytes_accum <= bytes_accum - pkfa_pkg::BTOTAL_W'(rdata.bytes) - OVH;
            duration_accum <= duration_accum -
                              pkfa_pkg::DTOTAL_W'(rdata.duration);
          end
        end
        pkfa_pkg::OP_FLUSH: begin
          rd_ptr         <= '0;
          wr_ptr         <= '0;
          count          <= '0;
          bytes_accum    <= '0;
          duration_accum <= '0;
          current_serial <= current_serial + 1'b1;
        end
        pkfa_pkg::OP_START: begin
          aborted        <= 1'b0;
          current_serial <= current_serial + 1'b1;
        end
        pkfa_pkg::OP_ABORT: begin
          aborted <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Any nonzero high part makes the product at least 2^32, above every den.
  assign long_enough = ((cfg.tb_num != '0) &&
                        (duration_accum[pkfa_pkg::DTOTAL_W-1:pkfa_pkg::TB_W] != '0)) ||
                       (prod > (2*pkfa_pkg::TB_W)'(cfg.tb_den));
  assign enough_next = cfg.stream_absent || aborted || cfg.attached_picture ||
                       ((pkfa_pkg::MINPKT_W'(count) > cfg.min_packets) &&
                        ((duration_accum == '0) || long_enough));

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status         <= status_r;
      out_handle     <= get_ok ? rdata.handle   : '0;
      out_bytes      <= get_ok ? rdata.bytes    : '0;
      out_duration   <= get_ok ? rdata.duration : '0;
      out_serial     <= get_ok ? rdata.serial   : '0;
      packet_count   <= count;
      byte_total     <= bytes_accum;
      duration_total <= duration_accum;
      enough         <= enough_next;
    end
  end

endmodule

/* rtl/packet_fifo_with_accounting.sv */
// Packet descriptor queue with accounting: top level and configuration registers.
// One transaction in flight: the next is accepted only once the last result is loaded for delivery.
// Each transaction runs the capture/execute/multiply/deliver sequence around the registered
// descriptor memory read and the time base multiplier, and waits in deliver while the output is held.
// Reset (rst, synchronous): queue empty, serial zero, abort set, registers at defaults.
module packet_fifo_with_accounting #(
  parameter int unsigned DEPTH          = 64,
  parameter int unsigned ENTRY_OVERHEAD = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pkfa_pkg::OP_W-1:0]           operation,
  input  logic [pkfa_pkg::HANDLE_W-1:0]       pkt_handle,
  input  logic [pkfa_pkg::BYTES_W-1:0]        pkt_bytes,
  input  logic [pkfa_pkg::DUR_W-1:0]          pkt_duration,
  input  logic                                wait_if_empty,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pkfa_pkg::STATUS_W-1:0]       status,
  output logic [pkfa_pkg::HANDLE_W-1:0]       out_handle,
  output logic [pkfa_pkg::BYTES_W-1:0]        out_bytes,
  output logic [pkfa_pkg::DUR_W-1:0]          out_duration,
  output logic [pkfa_pkg::SERIAL_W-1:0]       out_serial,
  output logic [$clog2(DEPTH+1)-1:0]          packet_count,
  output logic [pkfa_pkg::BTOTAL_W-1:0]       byte_total,
  output logic [pkfa_pkg::DTOTAL_W-1:0]       duration_total,
  output logic                                enough,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pkfa_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [pkfa_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [pkfa_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pkfa_pkg::cfg_t                cfg;
  pkfa_pkg::cmd_t                cmd;
  logic                          wr_en;
  logic [pkfa_pkg::REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[pkfa_pkg::APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_packets      <= 16'd25;
      cfg.tb_num           <= 32'd1;
      cfg.tb_den           <= 32'd90000;
      cfg.stream_absent    <= 1'b0;
      cfg.attached_picture <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        pkfa_pkg::REG_MIN_PACKETS: cfg.min_packets <= pwdata[pkfa_pkg::MINPKT_W-1:0];
        pkfa_pkg::REG_TB_NUM:      cfg.tb_num      <= pwdata;
        pkfa_pkg::REG_TB_DEN:      cfg.tb_den      <= pwdata;
        pkfa_pkg::REG_STREAM_ABS:  cfg.stream_absent    <= pwdata[0];
        pkfa_pkg::REG_ATTACHED:    cfg.attached_picture <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pkfa_pkg::REG_MIN_PACKETS: prdata = pkfa_pkg::APB_DATA_W'(cfg.min_packets);
      pkfa_pkg::REG_TB_NUM:      prdata = cfg.tb_num;
      pkfa_pkg::REG_TB_DEN:      prdata = cfg.tb_den;
      pkfa_pkg::REG_STREAM_ABS:  prdata = pkfa_pkg::APB_DATA_W'(cfg.stream_absent);
      pkfa_pkg::REG_ATTACHED:    prdata = pkfa_pkg::APB_DATA_W'(cfg.attached_picture);
      default:                   prdata = '0;
    endcase
  end

  pkfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  pkfa_datapath #(
    .DEPTH          (DEPTH),
    .ENTRY_OVERHEAD (ENTRY_OVERHEAD),
    .CNT_W          (CNT_W)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg            (cfg),
    .operation      (operation),
    .pkt_handle     (pkt_handle),
    .pkt_bytes      (pkt_bytes),
    .pkt_duration   (pkt_duration),
    .wait_if_empty  (wait_if_empty),
    .status         (status),
    .out_handle     (out_handle),
    .out_bytes      (out_bytes),
    .out_duration   (out_duration),
    .out_serial     (out_serial),
    .packet_count   (packet_count),
    .byte_total     (byte_total),
    .duration_total (duration_total),
    .enough         (enough)
  );

endmodule

/* bench/packet_fifo_with_accounting_tb.sv */
// Self-checking testbench for the packet descriptor queue with byte/duration accounting.
module packet_fifo_with_accounting_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH          = 64;
  localparam int unsigned ENTRY_OVERHEAD = 16;
  localparam int unsigned CNT_W          = $clog2(DEPTH + 1);
  localparam int unsigned PTR_W          = $clog2(DEPTH);
  localparam int unsigned PROD_W         = pkfa_pkg::TB_W + pkfa_pkg::DTOTAL_W;
  localparam int unsigned CYCLE_LIMIT    = 500000;
  localparam int unsigned SETTLE_CYCLES  = 8;

  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  localparam logic [pkfa_pkg::OP_W-1:0] OP_RESERVED_FIRST = pkfa_pkg::OP_ABORT + 3'd1;
  localparam logic [pkfa_pkg::OP_W-1:0] OP_RESERVED_LAST  = '1;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [pkfa_pkg::OP_W-1:0]     op;
    logic [pkfa_pkg::HANDLE_W-1:0] handle;
    logic [pkfa_pkg::BYTES_W-1:0]  nbytes;
    logic [pkfa_pkg::DUR_W-1:0]    dur;
    logic                          wait_flag;
  } queue_cmd_t;

  typedef struct packed {
    logic [pkfa_pkg::STATUS_W-1:0] status;
    logic [pkfa_pkg::HANDLE_W-1:0] handle;
    logic [pkfa_pkg::BYTES_W-1:0]  nbytes;
    logic [pkfa_pkg::DUR_W-1:0]    dur;
    logic [pkfa_pkg::SERIAL_W-1:0] serial;
    logic [CNT_W-1:0]              count;
    logic [pkfa_pkg::BTOTAL_W-1:0] btotal;
    logic [pkfa_pkg::DTOTAL_W-1:0] dtotal;
    logic                          enough;
  } queue_resp_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [pkfa_pkg::OP_W-1:0]       operation = pkfa_pkg::OP_PUT;
  logic [pkfa_pkg::HANDLE_W-1:0]   pkt_handle = '0;
  logic [pkfa_pkg::BYTES_W-1:0]    pkt_bytes = '0;
  logic [pkfa_pkg::DUR_W-1:0]      pkt_duration = '0;
  logic                            wait_if_empty = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [pkfa_pkg::STATUS_W-1:0]   status;
  logic [pkfa_pkg::HANDLE_W-1:0]   out_handle;
  logic [pkfa_pkg::BYTES_W-1:0]    out_bytes;
  logic [pkfa_pkg::DUR_W-1:0]      out_duration;
  logic [pkfa_pkg::SERIAL_W-1:0]   out_serial;
  logic [CNT_W-1:0]                packet_count;
  logic [pkfa_pkg::BTOTAL_W-1:0]   byte_total;
  logic [pkfa_pkg::DTOTAL_W-1:0]   duration_total;
  logic                            enough;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [pkfa_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [pkfa_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [pkfa_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  // queue mirror
  logic [pkfa_pkg::HANDLE_W-1:0] slot_handle [DEPTH];
  logic [pkfa_pkg::BYTES_W-1:0]  slot_bytes  [DEPTH];
  logic [pkfa_pkg::DUR_W-1:0]    slot_dur    [DEPTH];
  logic [pkfa_pkg::SERIAL_W-1:0] slot_serial [DEPTH];
  logic [PTR_W-1:0]              rd_idx;
  logic [PTR_W-1:0]              wr_idx;
  logic [CNT_W-1:0]              q_count;
  logic [pkfa_pkg::BTOTAL_W-1:0] q_bytes;
  logic [pkfa_pkg::DTOTAL_W-1:0] q_dur;
  logic [pkfa_pkg::SERIAL_W-1:0] q_serial;
  logic                          q_aborted;
  pkfa_pkg::cfg_t                model_cfg;

  queue_resp_t pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;

  packet_fifo_with_accounting #(
    .DEPTH(DEPTH),
    .ENTRY_OVERHEAD(ENTRY_OVERHEAD)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .pkt_handle(pkt_handle),
    .pkt_bytes(pkt_bytes),
    .pkt_duration(pkt_duration),
    .wait_if_empty(wait_if_empty),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .out_handle(out_handle),
    .out_bytes(out_bytes),
    .out_duration(out_duration),
    .out_serial(out_serial),
    .packet_count(packet_count),
    .byte_total(byte_total),
    .duration_total(duration_total),
    .enough(enough),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
    end
  endtask

  function automatic logic enough_flag();
    logic [PROD_W-1:0] scaled;
    if (model_cfg.stream_absent || q_aborted || model_cfg.attached_picture) return 1'b1;
    scaled = PROD_W'(model_cfg.tb_num) * PROD_W'(q_dur);
    return (pkfa_pkg::MINPKT_W'(q_count) > model_cfg.min_packets) &&
           (q_dur == '0 || scaled > PROD_W'(model_cfg.tb_den));
  endfunction

  function automatic queue_resp_t queue_model_step(input queue_cmd_t c);
    queue_resp_t r;
    r = '0;
    r.status = pkfa_pkg::ST_OK;
    case (c.op)
      pkfa_pkg::OP_PUT: begin
        if (q_aborted) begin
          r.status = pkfa_pkg::ST_ABORTED;
        end else if (q_count >= FULL_CNT) begin
          r.status = pkfa_pkg::ST_FULL;
        end else begin
          slot_handle[wr_idx] = c.handle;
          slot_bytes[wr_idx]  = c.nbytes;
          slot_dur[wr_idx]    = c.dur;
          slot_serial[wr_idx] = q_serial;
          wr_idx  = (wr_idx == LAST_IDX) ? '0 : wr_idx + 1'b1;
          q_count = q_count + 1'b1;
          q_bytes = q_bytes + pkfa_pkg::BTOTAL_W'(c.nbytes) +
                    pkfa_pkg::BTOTAL_W'(ENTRY_OVERHEAD);
          q_dur   = q_dur + pkfa_pkg::DTOTAL_W'(c.dur);
        end
      end
      pkfa_pkg::OP_GET: begin
        if (q_aborted) begin
          r.status = pkfa_pkg::ST_ABORTED;
        end else if (q_count == '0) begin
          r.status = c.wait_flag ? pkfa_pkg::ST_EMPTY_WAIT : pkfa_pkg::ST_EMPTY;
        end else begin
          r.handle = slot_handle[rd_idx];
          r.nbytes = slot_bytes[rd_idx];
          r.dur    = slot_dur[rd_idx];
          r.serial = slot_serial[rd_idx];
          rd_idx  = (rd_idx == LAST_IDX) ? '0 : rd_idx + 1'b1;
          q_count = q_count - 1'b1;
          q_bytes = q_bytes - pkfa_pkg::BTOTAL_W'(r.nbytes) -
                    pkfa_pkg::BTOTAL_W'(ENTRY_OVERHEAD);
          q_dur   = q_dur - pkfa_pkg::DTOTAL_W'(r.dur);
        end
      end
      pkfa_pkg::OP_FLUSH: begin
        rd_idx   = '0;
        wr_idx   = '0;
        q_count  = '0;
        q_bytes  = '0;
        q_dur    = '0;
        q_serial = q_serial + 1'b1;
      end
      pkfa_pkg::OP_START: begin
        q_aborted = 1'b0;
        q_serial  = q_serial + 1'b1;
      end
      pkfa_pkg::OP_ABORT: begin
        q_aborted = 1'b1;
      end
      default: begin
      end
    endcase
    r.count  = q_count;
    r.btotal = q_bytes;
    r.dtotal = q_dur;
    r.enough = enough_flag();
    return r;
  endfunction

  always @(posedge clk) begin : result_check
    queue_resp_t want;
    out_ready <= ($urandom_range(99) >= stall_pct);
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        check_field("result with nothing pending", 64'd1, 64'd0);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 64'(status), 64'(want.status));
        check_field("out_handle", 64'(out_handle), 64'(want.handle));
        check_field("out_bytes", 64'(out_bytes), 64'(want.nbytes));
        check_field("out_duration", 64'(out_duration), 64'(want.dur));
        check_field("out_serial", 64'(out_serial), 64'(want.serial));
        check_field("packet_count", 64'(packet_count), 64'(want.count));
        check_field("byte_total", 64'(byte_total), 64'(want.btotal));
        check_field("duration_total", 64'(duration_total), 64'(want.dtotal));
        check_field("enough", 64'(enough), 64'(want.enough));
      end
    end
  end

  function automatic queue_cmd_t queue_cmd(input logic [pkfa_pkg::OP_W-1:0] op,
                                           input logic [pkfa_pkg::HANDLE_W-1:0] handle,
                                           input logic [pkfa_pkg::BYTES_W-1:0] nbytes,
                                           input logic [pkfa_pkg::DUR_W-1:0] dur,
                                           input logic wait_flag);
    queue_cmd_t c;
    c.op = op;
    c.handle = handle;
    c.nbytes = nbytes;
    c.dur = dur;
    c.wait_flag = wait_flag;
    return c;
  endfunction

  function automatic queue_cmd_t random_cmd(input int unsigned put_permille);
    queue_cmd_t c;
    int unsigned r;
    c.handle = $urandom;
    c.wait_flag = 1'($urandom_range(1));
    r = $urandom_range(9);
    if (r == 0) c.nbytes = '0;
    else if (r == 1) c.nbytes = '1;
    else if (r < 6) c.nbytes = pkfa_pkg::BYTES_W'($urandom_range(1500));
    else c.nbytes = pkfa_pkg::BYTES_W'($urandom);
    r = $urandom_range(9);
    if (r == 0) c.dur = '0;
    else if (r == 1) c.dur = '1;
    else if (r < 7) c.dur = pkfa_pkg::DUR_W'($urandom_range(6000));
    else c.dur = $urandom;
    r = $urandom_range(999);
    if (r < put_permille) c.op = pkfa_pkg::OP_PUT;
    else if (r < 960) c.op = pkfa_pkg::OP_GET;
    else if (r < 978) c.op = pkfa_pkg::OP_START;
    else if (r < 986) c.op = pkfa_pkg::OP_FLUSH;
    else if (r < 990) c.op = pkfa_pkg::OP_ABORT;
    else c.op = pkfa_pkg::OP_W'($urandom_range(OP_RESERVED_LAST, OP_RESERVED_FIRST));
    return c;
  endfunction

  task automatic send_item(input queue_cmd_t c);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= c.op;
    pkt_handle    <= c.handle;
    pkt_bytes     <= c.nbytes;
    pkt_duration  <= c.dur;
    wait_if_empty <= c.wait_flag;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(queue_model_step(c));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_gap_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin send_gap_pct = 58; stall_pct = 0;  end
      IDLE_RECEIVER: begin send_gap_pct = 0;  stall_pct = 58; end
      default:       begin send_gap_pct = 38; stall_pct = 38; end
    endcase
  endtask

  // register write followed by a read back; queue must be idle
  task automatic cfg_write(input logic [pkfa_pkg::REG_IDX_W-1:0] idx,
                           input logic [pkfa_pkg::APB_DATA_W-1:0] value);
    logic [pkfa_pkg::APB_DATA_W-1:0] readback;
    logic [pkfa_pkg::APB_DATA_W-1:0] want;
    wait_for_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      pkfa_pkg::REG_MIN_PACKETS: begin
        model_cfg.min_packets = value[pkfa_pkg::MINPKT_W-1:0];
        want = pkfa_pkg::APB_DATA_W'(value[pkfa_pkg::MINPKT_W-1:0]);
      end
      pkfa_pkg::REG_TB_NUM: begin
        model_cfg.tb_num = value;
        want = value;
      end
      pkfa_pkg::REG_TB_DEN: begin
        model_cfg.tb_den = value;
        want = value;
      end
      pkfa_pkg::REG_STREAM_ABS: begin
        model_cfg.stream_absent = value[0];
        want = pkfa_pkg::APB_DATA_W'(value[0]);
      end
      default: begin
        model_cfg.attached_picture = value[0];
        want = pkfa_pkg::APB_DATA_W'(value[0]);
      end
    endcase
    check_field("register readback", 64'(readback), 64'(want));
  endtask

  task automatic apply_setting(input logic [pkfa_pkg::MINPKT_W-1:0] min_pk,
                               input logic [pkfa_pkg::TB_W-1:0] num,
                               input logic [pkfa_pkg::TB_W-1:0] den, input logic absent,
                               input logic attached);
    cfg_write(pkfa_pkg::REG_MIN_PACKETS, pkfa_pkg::APB_DATA_W'(min_pk));
    cfg_write(pkfa_pkg::REG_TB_NUM, num);
    cfg_write(pkfa_pkg::REG_TB_DEN, den);
    cfg_write(pkfa_pkg::REG_STREAM_ABS, pkfa_pkg::APB_DATA_W'(absent));
    cfg_write(pkfa_pkg::REG_ATTACHED, pkfa_pkg::APB_DATA_W'(attached));
  endtask

  // alternating fill/drain bursts so the queue hits both full and empty
  task automatic run_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned burst;
    logic filling;
    sent = 0;
    filling = 1'($urandom_range(1));
    while (sent < n_items) begin
      burst = $urandom_range(120, 40);
      for (int unsigned i = 0; i < burst && sent < n_items; i++) begin
        send_item(random_cmd(filling ? 900 : 200));
        sent++;
      end
      filling = !filling;
    end
  endtask

  task automatic test_abort_at_reset();
    send_item(queue_cmd(pkfa_pkg::OP_PUT, 32'h1, 24'h10, 32'h100, 1'b0));
    send_item(queue_cmd(pkfa_pkg::OP_GET, '0, '0, '0, 1'b1));
    send_item(queue_cmd(pkfa_pkg::OP_GET, '0, '0, '0, 1'b0));
    send_item(queue_cmd(OP_RESERVED_FIRST, '1, '1, '1, 1'b1));
    send_item(queue_cmd(OP_RESERVED_LAST, '0, '0, '0, 1'b0));
    send_item(queue_cmd(pkfa_pkg::OP_ABORT, '0, '0, '0, 1'b0));
    send_item(queue_cmd(pkfa_pkg::OP_START, '0, '0, '0, 1'b0));
  endtask

  task automatic test_queue_ops();
    send_item(queue_cmd(pkfa_pkg::OP_PUT, '0, '0, '0, 1'b0));
    send_item(queue_cmd(pkfa_pkg::OP_PUT, '1, '1, '1, 1'b1));
    send_item(queue_cmd(pkfa_pkg::OP_PUT, 32'hA5A5_5A5A, 24'h5A_A55A, 32'h1234_5678, 1'b0));
    send_item(queue_cmd(pkfa_pkg::OP_GET, '1, '1, '1, 1'b1));
    send_item(queue_cmd(pkfa_pkg::OP_GET, '0, '0, '0, 1'b0));
    send_item(queue_cmd(pkfa_pkg::OP_GET, '0, '0, '0, 1'b0));
    send_item(queue_cmd(pkfa_pkg::OP_GET, '0, '0, '0, 1'b0));
    send_item(queue_cmd(pkfa_pkg::OP_GET, '0, '0, '0, 1'b1));
    send_item(queue_cmd(pkfa_pkg::OP_PUT, 32'h5A5A_A5A5, 24'hA5_5AA5, 32'hEDCB_A987, 1'b1));
    send_item(queue_cmd(pkfa_pkg::OP_FLUSH, '0, '0, '0, 1'b0));
    send_item(queue_cmd(pkfa_pkg::OP_GET, '0, '0, '0, 1'b1));
    send_item(queue_cmd(pkfa_pkg::OP_PUT, 32'h77, 24'h99, 32'h55, 1'b0));
    send_item(queue_cmd(pkfa_pkg::OP_ABORT, '0, '0, '0, 1'b0));
    send_item(queue_cmd(pkfa_pkg::OP_PUT, 32'h78, 24'h9A, 32'h56, 1'b0));
    send_item(queue_cmd(pkfa_pkg::OP_START, '0, '0, '0, 1'b0));
    send_item(queue_cmd(pkfa_pkg::OP_GET, '0, '0, '0, 1'b0));
  endtask

  task automatic test_time_base_rule();
    apply_setting(16'd0, 32'd1, 32'd90000, 1'b0, 1'b0);
    send_item(queue_cmd(pkfa_pkg::OP_FLUSH, '0, '0, '0, 1'b0));
    send_item(queue_cmd(pkfa_pkg::OP_PUT, 32'h10, 24'd100, 32'd0, 1'b0));
    send_item(queue_cmd(pkfa_pkg::OP_PUT, 32'h11, 24'd100, 32'd90000, 1'b0));
    send_item(queue_cmd(pkfa_pkg::OP_PUT, 32'h12, 24'd100, 32'd1, 1'b0));
    cfg_write(pkfa_pkg::REG_STREAM_ABS, 32'd1);
    send_item(queue_cmd(pkfa_pkg::OP_GET, '0, '0, '0, 1'b0));
    cfg_write(pkfa_pkg::REG_STREAM_ABS, 32'd0);
    cfg_write(pkfa_pkg::REG_ATTACHED, 32'd1);
    send_item(queue_cmd(pkfa_pkg::OP_GET, '0, '0, '0, 1'b0));
    cfg_write(pkfa_pkg::REG_ATTACHED, 32'd0);
    // zero numerator: product never exceeds the denominator
    cfg_write(pkfa_pkg::REG_TB_NUM, 32'd0);
    send_item(queue_cmd(pkfa_pkg::OP_PUT, 32'h13, 24'd7, 32'd5, 1'b0));
    apply_setting(16'd0, 32'd1, '1, 1'b0, 1'b0);
    send_item(queue_cmd(pkfa_pkg::OP_FLUSH, '0, '0, '0, 1'b0));
    send_item(queue_cmd(pkfa_pkg::OP_PUT, 32'h14, '1, '1, 1'b0));
    send_item(queue_cmd(pkfa_pkg::OP_PUT, 32'h15, '1, '1, 1'b0));
    cfg_write(pkfa_pkg::REG_MIN_PACKETS, '1);
    send_item(queue_cmd(pkfa_pkg::OP_PUT, 32'h16, 24'd1, 32'd1, 1'b0));
    send_item(queue_cmd(pkfa_pkg::OP_FLUSH, '0, '0, '0, 1'b0));
  endtask

  task automatic test_config_sweep();
    apply_setting(16'd0, '1, 32'd1, 1'b0, 1'b0);
    set_idling(IDLE_NONE);
    run_traffic(60);
    apply_setting('1, 32'd1, '1, 1'b0, 1'b0);
    set_idling(IDLE_BOTH);
    run_traffic(60);
    for (int k = 0; k < 4; k++) begin
      apply_setting(pkfa_pkg::MINPKT_W'($urandom_range(63)), $urandom_range(12, 1),
                    $urandom_range(300000, 1000), 1'b0, 1'b0);
      set_idling(idle_mode_t'(k));
      run_traffic(60);
    end
    apply_setting(16'd10, 32'd1, 32'd90000, 1'b1, 1'b0);
    set_idling(IDLE_RECEIVER);
    run_traffic(40);
    apply_setting(16'd10, 32'd1, 32'd90000, 1'b0, 1'b1);
    set_idling(IDLE_SENDER);
    run_traffic(40);
    apply_setting(16'd25, 32'd1, 32'd90000, 1'b0, 1'b0);
  endtask

  task automatic test_random_traffic();
    set_idling(IDLE_NONE);
    run_traffic(250);
    set_idling(IDLE_SENDER);
    run_traffic(250);
    wait_for_results();
    set_idling(IDLE_RECEIVER);
    run_traffic(250);
    set_idling(IDLE_BOTH);
    run_traffic(250);
  endtask

  initial begin
    rd_idx    = '0;
    wr_idx    = '0;
    q_count   = '0;
    q_bytes   = '0;
    q_dur     = '0;
    q_serial  = '0;
    q_aborted = 1'b1;
    model_cfg.min_packets      = 16'd25;
    model_cfg.tb_num           = 32'd1;
    model_cfg.tb_den           = 32'd90000;
    model_cfg.stream_absent    = 1'b0;
    model_cfg.attached_picture = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_abort_at_reset();
    test_queue_ops();
    test_time_base_rule();
    test_config_sweep();
    test_random_traffic();

    wait_for_results();
    repeat (12) @(posedge clk);
    check_field("results left over", 64'(pending_results.size()), 64'd0);
    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
